FILE: src/stepper_ramp_step_generator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stepper ramp step generator
// Concurrent checks clocked by i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEPPER_RAMP_STEP_GENERATOR_MACROS_SVH
`define STEPPER_RAMP_STEP_GENERATOR_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define SRSG_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("srsg assertion failed");

// consequent must hold in the cycle after the antecedent
`define SRSG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srsg assertion failed");

`else

`define SRSG_ASSERT(label, prop)
`define SRSG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/srsg_pkg.sv
// ----------------------------------------------------------------------------
// srsg_pkg
// Shared types, widths and codes of the stepper ramp step generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srsg_pkg;

    // fixed field widths
    localparam int PERIOD_W   = 32;
    localparam int ACCEL_W    = 41;
    localparam int ASTEP_W    = 24;
    localparam int DELTA_W    = PERIOD_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 41;

    // parameter defaults
    localparam int DEF_POSITION_BITS    = 32;
    localparam int DEF_PERIOD_FRAC_BITS = 12;
    localparam int DEF_ACCEL_FRAC_BITS  = 60;

    // deceleration distance numerator constant, 5e11
    localparam int             DECEL_K_W = 39;
    localparam logic [38:0]    DECEL_K   = 39'd500000000000;

    // operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_TARGET = 2'd1;
    localparam logic [1:0] OP_PRESET = 2'd2;
    localparam logic [1:0] OP_STOP   = 2'd3;

    // motion direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOWEST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOPMIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ASTEP   = 3'd4;

    // register reset values
    localparam logic [PERIOD_W-1:0] RST_CRUISE  = 32'd20480000;
    localparam logic [PERIOD_W-1:0] RST_SLOWEST = 32'd204800000;
    localparam logic [PERIOD_W-1:0] RST_STOPMIN = 32'd73142857;
    localparam logic [ACCEL_W-1:0]  RST_ACCEL   = 41'd230584301;
    localparam logic [ASTEP_W-1:0]  RST_ASTEP   = 24'd200;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic               step_pulse;
        logic               dir_level;
        logic signed [31:0] position;
        logic [31:0]        current_period;
        logic               motion_done;
    } t_out;

    // request to the ramp math engine
    typedef struct packed {
        logic                start;
        logic [PERIOD_W-1:0] period;
    } t_math_req;

    // status of the ramp math engine
    typedef struct packed {
        logic busy;
        logic done;
    } t_math_stat;

endpackage

`default_nettype wire

FILE: src/stepper_ramp_step_generator.sv
// ----------------------------------------------------------------------------
// Stepper ramp step generator: step/direction pulses on a linear speed ramp.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one transaction per
// microsecond tick, new target, position preset or stop request. Output
// channel (o_out_valid / i_out_stall / o_out_data): exactly one result
// transaction per input, in order. Config channel (i_cfg_valid / o_cfg_ready):
// register writes, always ready, to be issued while the block is idle.
// One item is handled at a time; o_in_stall is high from acceptance until
// the result is placed in the output register.
// A tick without a step, a target or a preset goes straight to the output state.
// A tick that steps and a stop request while moving run the ramp math sequencer:
// shift-add multiplies for p squared, the denominator, p cubed and the period
// change (one bit per cycle on the shared adder), then a restoring divide with
// one divide cycle per numerator bit.
// The output register lets the next item be accepted while a result waits;
// a finished item waits in its last state while the receiver stalls.
// Synchronous reset clears position, target, motion and the output valid flag,
// and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_ramp_step_generator_macros.svh"

module stepper_ramp_step_generator import srsg_pkg::*; #(
    parameter int POSITION_BITS    = DEF_POSITION_BITS,
    parameter int PERIOD_FRAC_BITS = DEF_PERIOD_FRAC_BITS,
    parameter int ACCEL_FRAC_BITS  = DEF_ACCEL_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PB = POSITION_BITS;

    localparam logic signed [PB+1:0] POS_HI = {3'b000, {(PB-1){1'b1}}};
    localparam logic signed [PB+1:0] POS_LO = ~POS_HI;

    // sequencer codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MATH   = 3'd1;
    localparam logic [2:0] S_CHOOSE = 3'd2;
    localparam logic [2:0] S_FIN    = 3'd3;
    localparam logic [2:0] S_STOPT  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    // configuration
    logic [PERIOD_W-1:0] r_cruise, r_slowest, r_stopmin;
    logic [ACCEL_W-1:0]  r_accel;
    logic [ASTEP_W-1:0]  r_astep;

    // motion state
    logic [2:0]              r_state, n_state;
    logic signed [PB-1:0]    r_pos, n_pos;
    logic signed [PB-1:0]    r_tgt, n_tgt;
    logic [1:0]              r_dir, n_dir;
    logic [PERIOD_W-1:0]     r_step_p, n_step_p;
    logic [PERIOD_W-1:0]     r_next_p, n_next_p;
    logic [31:0]             r_elapsed, n_elapsed;
    logic                    r_dirline, n_dirline;
    logic                    r_stepped, n_stepped;
    logic                    r_is_stop, n_is_stop;
    logic                    r_ahead, n_ahead;
    logic [PB:0]             r_dist, n_dist;
    t_math_req               r_req, n_req;
    t_out                    r_out, n_out;
    logic                    r_out_valid, n_out_valid;

    t_math_stat              math_stat;
    logic [PB:0]             dd;
    logic [DELTA_W-1:0]      delta;

    logic                    accept;
    logic [31:0]             e_inc;
    logic                    step_due;
    logic signed [PB:0]      diff;
    logic                    toward;
    logic [PERIOD_W-1:0]     v_dn, next_fast;
    logic [PERIOD_W+1:0]     v_up;
    logic [PERIOD_W-1:0]     next_slow;
    logic signed [PB+1:0]    stop_t;
    logic                    out_load;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;

    // tick timing
    assign e_inc    = (r_elapsed == '1) ? r_elapsed : r_elapsed + 32'd1;
    assign step_due = !(e_inc < (r_next_p >> PERIOD_FRAC_BITS));

    // distance to target
    assign diff = (PB + 1)'(r_tgt) - (PB + 1)'(r_pos);

    // candidate next periods
    assign toward    = (r_dir == DIR_POS && r_ahead) || (r_dir == DIR_NEG && !r_ahead);
    assign v_dn      = ({1'b0, r_step_p} > delta) ? r_step_p - delta[PERIOD_W-1:0] : '0;
    assign next_fast = (v_dn < r_cruise) ? r_cruise : v_dn;
    assign v_up      = {2'b00, r_step_p} + {1'b0, delta};
    assign next_slow = (v_up > {2'b00, r_slowest}) ? r_slowest : v_up[PERIOD_W-1:0];

    // stop target before clamping
    assign stop_t = (r_dir == DIR_POS) ? (PB + 2)'(r_pos) + $signed({1'b0, dd})
                                       : (PB + 2)'(r_pos) - $signed({1'b0, dd});

    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    srsg_math #(
        .POSITION_BITS    (POSITION_BITS),
        .PERIOD_FRAC_BITS (PERIOD_FRAC_BITS),
        .ACCEL_FRAC_BITS  (ACCEL_FRAC_BITS)
    ) u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_accel (r_accel),
        .i_astep (r_astep),
        .o_stat  (math_stat),
        .o_dd    (dd),
        .o_delta (delta)
    );

    // item sequencer
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_tgt       = r_tgt;
        n_dir       = r_dir;
        n_step_p    = r_step_p;
        n_next_p    = r_next_p;
        n_elapsed   = r_elapsed;
        n_dirline   = r_dirline;
        n_stepped   = r_stepped;
        n_is_stop   = r_is_stop;
        n_ahead     = r_ahead;
        n_dist      = r_dist;
        n_req       = r_req;
        n_req.start = 1'b0;
        n_out       = r_out;
        n_out_valid = i_out_stall ? r_out_valid : 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_stepped = 1'b0;
                    n_state   = S_OUT;
                    case (i_in_data.op)
                        OP_TICK: begin
                            if (r_dir == DIR_STOP) begin
                                // start motion at the slowest period, no step yet
                                if (r_tgt != r_pos) begin
                                    n_dir     = (r_tgt > r_pos) ? DIR_POS : DIR_NEG;
                                    n_dirline = !(r_tgt > r_pos);
                                    n_next_p  = r_slowest;
                                    n_elapsed = '0;
                                end
                            end else if (!step_due) begin
                                n_elapsed = e_inc;
                            end else begin
                                n_pos       = (r_dir == DIR_POS) ? r_pos + PB'(1)
                                                                 : r_pos - PB'(1);
                                n_step_p    = r_next_p;
                                n_elapsed   = '0;
                                n_stepped   = 1'b1;
                                n_is_stop   = 1'b0;
                                n_req.start = 1'b1;
                                n_req.period = r_next_p;
                                n_state     = S_MATH;
                            end
                        end
                        OP_TARGET: begin
                            n_tgt = PB'(i_in_data.value);
                        end
                        OP_PRESET: begin
                            n_pos = PB'(i_in_data.value);
                        end
                        OP_STOP: begin
                            if (r_step_p != '0) begin
                                n_is_stop    = 1'b1;
                                n_req.start  = 1'b1;
                                n_req.period = r_step_p;
                                n_state      = S_MATH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MATH: begin
                n_ahead = !diff[PB];
                n_dist  = diff[PB] ? -diff : diff;
                if (math_stat.done) begin
                    n_state = r_is_stop ? S_STOPT : S_CHOOSE;
                end
            end
            S_CHOOSE: begin
                // accelerate, decelerate or reverse
                if (toward) begin
                    if (r_dist < dd || r_next_p < r_cruise) begin
                        n_next_p = next_slow;
                    end else begin
                        n_next_p = next_fast;
                    end
                end else if (r_step_p < r_slowest) begin
                    n_next_p = next_slow;
                end else begin
                    n_dir     = r_ahead ? DIR_POS : DIR_NEG;
                    n_dirline = !r_ahead;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                // stop at target once slow enough
                if (r_pos == r_tgt && r_next_p >= r_stopmin) begin
                    n_step_p = '0;
                    n_next_p = '0;
                    n_dir    = DIR_STOP;
                end
                n_state = S_OUT;
            end
            S_STOPT: begin
                if (stop_t > POS_HI) begin
                    n_tgt = POS_HI[PB-1:0];
                end else if (stop_t < POS_LO) begin
                    n_tgt = POS_LO[PB-1:0];
                end else begin
                    n_tgt = stop_t[PB-1:0];
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_out.step_pulse     = r_stepped;
                    n_out.dir_level      = r_dirline;
                    n_out.position       = 32'(r_pos);
                    n_out.current_period = r_step_p;
                    n_out.motion_done    = (r_dir == DIR_STOP) && (r_pos == r_tgt);
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_tgt       <= '0;
            r_dir       <= DIR_STOP;
            r_step_p    <= '0;
            r_next_p    <= '0;
            r_elapsed   <= '0;
            r_dirline   <= 1'b0;
            r_req.start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_tgt       <= n_tgt;
            r_dir       <= n_dir;
            r_step_p    <= n_step_p;
            r_next_p    <= n_next_p;
            r_elapsed   <= n_elapsed;
            r_dirline   <= n_dirline;
            r_req.start <= n_req.start;
            r_out_valid <= n_out_valid;
        end
        r_req.period <= n_req.period;
        r_stepped    <= n_stepped;
        r_is_stop    <= n_is_stop;
        r_ahead      <= n_ahead;
        r_dist       <= n_dist;
        r_out        <= n_out;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise  <= RST_CRUISE;
            r_slowest <= RST_SLOWEST;
            r_stopmin <= RST_STOPMIN;
            r_accel   <= RST_ACCEL;
            r_astep   <= RST_ASTEP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_CRUISE:  r_cruise  <= i_cfg_data[PERIOD_W-1:0];
                REG_SLOWEST: r_slowest <= i_cfg_data[PERIOD_W-1:0];
                REG_STOPMIN: r_stopmin <= i_cfg_data[PERIOD_W-1:0];
                REG_ACCEL:   r_accel   <= i_cfg_data[ACCEL_W-1:0];
                REG_ASTEP:   r_astep   <= i_cfg_data[ASTEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `SRSG_ASSERT(a_math_busy_stalls, math_stat.busy |-> o_in_stall)
    `SRSG_ASSERT(a_math_done_waited, math_stat.done |-> (r_state == S_MATH))
    `SRSG_ASSERT(a_stopped_no_period, (r_dir == DIR_STOP) |-> (r_step_p == '0))
    `SRSG_ASSERT_NEXT(a_accept_stalls, accept, o_in_stall)

endmodule

`default_nettype wire

FILE: src/srsg_alu.sv
// ----------------------------------------------------------------------------
// srsg_alu
// Shared wide add/subtract unit; carry out is the no-borrow flag on subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsg_alu import srsg_pkg::*; #(
    parameter int WIDTH = PERIOD_W
) (
    input  wire logic [WIDTH-1:0] i_a,
    input  wire logic [WIDTH-1:0] i_b,
    input  wire logic             i_sub,
    output logic      [WIDTH-1:0] o_sum,
    output logic                  o_carry
);

    logic [WIDTH-1:0] b_op;

    assign b_op = i_sub ? ~i_b : i_b;
    assign {o_carry, o_sum} = {1'b0, i_a} + {1'b0, b_op} + (WIDTH + 1)'(i_sub);

endmodule

`default_nettype wire

FILE: src/srsg_math.sv
// ----------------------------------------------------------------------------
// srsg_math
// Sequencer computing deceleration distance and period change for one period
// with a single shift-add multiplier and restoring divider on a shared adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsg_math import srsg_pkg::*; #(
    parameter int POSITION_BITS    = DEF_POSITION_BITS,
    parameter int PERIOD_FRAC_BITS = DEF_PERIOD_FRAC_BITS,
    parameter int ACCEL_FRAC_BITS  = DEF_ACCEL_FRAC_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_math_req              i_req,
    input  wire logic [ACCEL_W-1:0]     i_accel,
    input  wire logic [ASTEP_W-1:0]     i_astep,
    output t_math_stat                  o_stat,
    output logic [POSITION_BITS:0]      o_dd,
    output logic [DELTA_W-1:0]          o_delta
);

    localparam int PW   = PERIOD_W;
    localparam int MLW  = ACCEL_W;
    localparam int PPW  = 2 * PW;
    localparam int DENW = PPW + ASTEP_W;
    localparam int P3W  = 3 * PW;
    localparam int MULW = P3W + ACCEL_W;
    localparam int SHR  = ACCEL_FRAC_BITS + 2 * PERIOD_FRAC_BITS;
    localparam int KSH  = 2 * PERIOD_FRAC_BITS + 1;
    localparam int KNW  = DECEL_K_W + KSH;
    localparam int NW   = ((KNW > DENW) ? KNW : DENW) + 1;
    localparam int RW   = DENW + 2;
    localparam int UW0  = (MULW > RW) ? MULW : RW;
    localparam int UW   = (UW0 > NW) ? UW0 : NW;
    localparam int CW   = $clog2(((NW > MLW) ? NW : MLW) + 1);
    localparam int DDW  = POSITION_BITS + 1;

    localparam logic [DDW-1:0] CAP = {1'b1, {POSITION_BITS{1'b0}}};

    // sequencer codes
    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_PP   = 3'd1;
    localparam logic [2:0] M_DEN  = 3'd2;
    localparam logic [2:0] M_P3   = 3'd3;
    localparam logic [2:0] M_T    = 3'd4;
    localparam logic [2:0] M_NUM  = 3'd5;
    localparam logic [2:0] M_DIV  = 3'd6;
    localparam logic [2:0] M_DONE = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [PW-1:0]       r_p, n_p;
    logic [MULW-1:0]     r_acc, n_acc;
    logic [MULW-1:0]     r_mcand, n_mcand;
    logic [MLW-1:0]      r_mult, n_mult;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [PPW-1:0]      r_pp, n_pp;
    logic [DENW-1:0]     r_den, n_den;
    logic [RW-1:0]       r_rem, n_rem;
    logic [NW-1:0]       r_quo, n_quo;
    logic [DDW-1:0]      r_dd, n_dd;
    logic [DELTA_W-1:0]  r_delta, n_delta;

    logic [UW-1:0]       alu_a, alu_b, alu_sum;
    logic                alu_sub, alu_carry;
    logic                mul_phase, last;
    logic [RW-1:0]       rem_sh;
    logic [NW-1:0]       quo_n;
    logic [MULW-1:0]     t_shr;

    assign mul_phase = r_state inside {M_PP, M_DEN, M_P3, M_T};
    assign last      = (r_cnt == CW'(1));
    assign rem_sh    = {r_rem[RW-2:0], r_quo[NW-1]};
    assign quo_n     = {r_quo[NW-2:0], alu_carry};
    assign t_shr     = alu_sum[MULW-1:0] >> SHR;

    // shared adder operand selection
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        if (mul_phase) begin
            alu_a = UW'(r_acc);
            alu_b = r_mult[0] ? UW'(r_mcand) : '0;
        end else if (r_state == M_NUM) begin
            alu_a = UW'(DECEL_K) << KSH;
            alu_b = UW'(r_den);
        end else if (r_state == M_DIV) begin
            alu_a   = UW'(rem_sh);
            alu_b   = UW'({r_den, 1'b0});
            alu_sub = 1'b1;
        end
    end

    srsg_alu #(
        .WIDTH (UW)
    ) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_p     = r_p;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_mult  = r_mult;
        n_cnt   = r_cnt;
        n_pp    = r_pp;
        n_den   = r_den;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dd    = r_dd;
        n_delta = r_delta;
        if (mul_phase) begin
            n_acc   = alu_sum[MULW-1:0];
            n_mcand = r_mcand << 1;
            n_mult  = r_mult >> 1;
            n_cnt   = r_cnt - 1'b1;
        end
        case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    n_p     = i_req.period;
                    n_acc   = '0;
                    n_mcand = MULW'(i_req.period);
                    n_mult  = MLW'(i_req.period);
                    n_cnt   = CW'(PW);
                    n_state = M_PP;
                end
            end
            M_PP: begin
                // p squared done: multiply by steps/s^2
                if (last) begin
                    n_pp    = alu_sum[PPW-1:0];
                    n_acc   = '0;
                    n_mcand = MULW'(alu_sum[PPW-1:0]);
                    n_mult  = MLW'(i_astep);
                    n_cnt   = CW'(ASTEP_W);
                    n_state = M_DEN;
                end
            end
            M_DEN: begin
                if (last) begin
                    n_den   = alu_sum[DENW-1:0];
                    n_acc   = '0;
                    n_mcand = MULW'(r_pp);
                    n_mult  = MLW'(r_p);
                    n_cnt   = CW'(PW);
                    n_state = M_P3;
                end
            end
            M_P3: begin
                // p cubed done: multiply by accel
                if (last) begin
                    n_acc   = '0;
                    n_mcand = MULW'(alu_sum[P3W-1:0]);
                    n_mult  = i_accel;
                    n_cnt   = CW'(ACCEL_W);
                    n_state = M_T;
                end
            end
            M_T: begin
                // period change, clipped just above any period
                if (last) begin
                    n_delta = (|t_shr[MULW-1:PW]) ? {1'b1, {PW{1'b0}}} : t_shr[DELTA_W-1:0];
                    n_state = M_NUM;
                end
            end
            M_NUM: begin
                // numerator with rounding term; zero divisor saturates
                if (r_den == '0) begin
                    n_dd    = CAP;
                    n_state = M_DONE;
                end else begin
                    n_quo   = alu_sum[NW-1:0];
                    n_rem   = '0;
                    n_cnt   = CW'(NW);
                    n_state = M_DIV;
                end
            end
            M_DIV: begin
                n_rem = alu_carry ? alu_sum[RW-1:0] : rem_sh;
                n_quo = quo_n;
                n_cnt = r_cnt - 1'b1;
                if (last) begin
                    n_dd    = (quo_n > NW'(CAP)) ? CAP : quo_n[DDW-1:0];
                    n_state = M_DONE;
                end
            end
            M_DONE: begin
                n_state = M_IDLE;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_p     <= n_p;
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
        r_mult  <= n_mult;
        r_cnt   <= n_cnt;
        r_pp    <= n_pp;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dd    <= n_dd;
        r_delta <= n_delta;
    end

    assign o_stat.busy = (r_state != M_IDLE);
    assign o_stat.done = (r_state == M_DONE);
    assign o_dd        = r_dd;
    assign o_delta     = r_delta;

endmodule

`default_nettype wire
